// File: design/serial_message_deframer_core_macros.svh
// Assertion macros shared by the deframer checker.
`ifndef SERIAL_MESSAGE_DEFRAMER_CORE_MACROS_SVH
`define SERIAL_MESSAGE_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked while out of reset.
`define SMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// File: design/smd_pkg.sv
// Package with constants and types of the serial message deframer.
package smd_pkg;

    localparam int FRAME_BYTES = 128;
    localparam int HDR_BYTES   = 5;
    localparam int LIMIT_W     = $clog2(FRAME_BYTES + 1);

    localparam logic [1:0] REG_START_CODE  = 2'd0;
    localparam logic [1:0] REG_TOKEN_CODE  = 2'd1;
    localparam logic [1:0] REG_END_CODE    = 2'd2;
    localparam logic [1:0] REG_FRAME_LIMIT = 2'd3;

    localparam logic [7:0] RST_START_CODE  = 8'd27;
    localparam logic [7:0] RST_TOKEN_CODE  = 8'd14;
    localparam logic [7:0] RST_END_CODE    = 8'd13;
    localparam logic [7:0] RST_FRAME_LIMIT = 8'd100;

    typedef enum logic [8:0] {
        ST_HUNT    = 9'b000000001,
        ST_ADDR    = 9'b000000010,
        ST_INDEX   = 9'b000000100,
        ST_LENGTH  = 9'b000001000,
        ST_TOKEN   = 9'b000010000,
        ST_DATA    = 9'b000100000,
        ST_CHECK_L = 9'b001000000,
        ST_CHECK_H = 9'b010000000,
        ST_END     = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [15:0] frame_check;
        logic [7:0]  frame_length;
        logic [7:0]  frame_index;
        logic [7:0]  frame_addr;
        logic        frame_dropped;
        logic        is_payload;
        logic [6:0]  byte_position;
        logic        byte_stored;
        logic [7:0]  byte_value;
    } result_t;

    typedef struct packed {
        result_t data;
        logic    done;
    } item_t;

endpackage

// File: design/serial_message_deframer_core.sv
// Top level of the serial message deframer: byte parser with a skid-buffered result port.
//
//  Channel  Ports          Payload
//  -------  -------------  ---------------------------------------------------------
//  input    s_tvalid ...   s_tdata[7:0] rx_byte
//  result   m_tvalid ...   m_tdata fields as listed at the port, m_tlast frame_done
//  config   cfg_valid ...  cfg_index register index, cfg_data register value
//
// One byte is accepted per cycle unless the input stalls; its result is registered into the
// output or skid register. The parser state updates in the cycle the byte is accepted.
// A two-entry output stage (output register plus skid register) keeps the input open
// for one more byte while a result waits; the input stalls only when both hold items.
// Reset is synchronous and active low; configuration registers return to their defaults.
module serial_message_deframer_core import smd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] byte_value, [8] byte_stored, [15:9] byte_position, [16] is_payload,
    // [17] frame_dropped, [25:18] frame_addr, [33:26] frame_index,
    // [41:34] frame_length, [57:42] frame_check, [63:58] zero
    output logic [63:0] m_tdata,
    output logic        m_tlast,    // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] start_code_reg;
    logic [7:0] token_code_reg;
    logic [7:0] end_code_reg;
    logic [7:0] frame_limit_reg;

    state_t     state_reg, state_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] index_reg, index_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] chk_lo_reg, chk_lo_next;
    logic [7:0] chk_hi_reg, chk_hi_next;

    item_t      out_reg, skid_reg, item_next;
    logic       out_valid_reg, skid_valid_reg;

    logic             push, pop;
    logic [7:0]       rx_byte;
    logic [7:0]       count_inc;
    logic [LIMIT_W-1:0] limit;
    logic             stored, payload, done, dropped;
    logic [6:0]       pos;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign push      = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;
    assign rx_byte   = s_tdata;
    assign count_inc = count_reg + 8'd1;

    always_comb begin
        if ({1'b0, frame_limit_reg} > (LIMIT_W + 1)'(FRAME_BYTES)) begin
            limit = LIMIT_W'(FRAME_BYTES);
        end else begin
            limit = LIMIT_W'(frame_limit_reg);
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        addr_next   = addr_reg;
        index_next  = index_reg;
        length_next = length_reg;
        chk_lo_next = chk_lo_reg;
        chk_hi_next = chk_hi_reg;
        stored      = 1'b0;
        payload     = 1'b0;
        done        = 1'b0;
        dropped     = 1'b0;
        pos         = count_reg[6:0];
        unique case (state_reg)
            ST_ADDR: begin
                stored     = 1'b1;
                count_next = count_inc;
                addr_next  = rx_byte;
                state_next = ST_INDEX;
            end
            ST_INDEX: begin
                stored     = 1'b1;
                count_next = count_inc;
                index_next = rx_byte;
                state_next = ST_LENGTH;
            end
            ST_LENGTH: begin
                stored      = 1'b1;
                count_next  = count_inc;
                length_next = rx_byte;
                left_next   = rx_byte;
                state_next  = ST_TOKEN;
            end
            ST_TOKEN: begin
                if (rx_byte == token_code_reg) begin
                    stored     = 1'b1;
                    count_next = count_inc;
                    state_next = (left_reg != 8'd0) ? ST_DATA : ST_CHECK_L;
                end else begin
                    dropped    = 1'b1;
                    state_next = ST_HUNT;
                end
            end
            ST_DATA: begin
                stored     = 1'b1;
                payload    = 1'b1;
                count_next = count_inc;
                left_next  = left_reg - 8'd1;
                if (left_reg == 8'd1) begin
                    state_next = ST_CHECK_L;
                end
                if (({2'b00, count_inc} + 10'(HDR_BYTES)) > 10'(limit)) begin
                    dropped    = 1'b1;
                    state_next = ST_HUNT;
                end
            end
            ST_CHECK_L: begin
                stored      = 1'b1;
                count_next  = count_inc;
                chk_lo_next = rx_byte;
                state_next  = ST_CHECK_H;
            end
            ST_CHECK_H: begin
                stored      = 1'b1;
                count_next  = count_inc;
                chk_hi_next = rx_byte;
                state_next  = ST_END;
            end
            ST_END: begin
                stored     = 1'b1;
                count_next = count_inc;
                state_next = ST_HUNT;
                if (rx_byte == end_code_reg) begin
                    done = 1'b1;
                end else begin
                    dropped = 1'b1;
                end
            end
            default: begin
                count_next = 8'd1;
                pos        = 7'd0;
                state_next = ST_HUNT;
                if (rx_byte == start_code_reg) begin
                    stored     = 1'b1;
                    state_next = ST_ADDR;
                end
            end
        endcase
    end

    always_comb begin
        item_next.done               = done;
        item_next.data.byte_value    = rx_byte;
        item_next.data.byte_stored   = stored;
        item_next.data.byte_position = stored ? pos : 7'd0;
        item_next.data.is_payload    = payload;
        item_next.data.frame_dropped = dropped;
        item_next.data.frame_addr    = done ? addr_reg : 8'd0;
        item_next.data.frame_index   = done ? index_reg : 8'd0;
        item_next.data.frame_length  = done ? length_reg : 8'd0;
        item_next.data.frame_check   = done ? {chk_hi_reg, chk_lo_reg} : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg  <= RST_START_CODE;
            token_code_reg  <= RST_TOKEN_CODE;
            end_code_reg    <= RST_END_CODE;
            frame_limit_reg <= RST_FRAME_LIMIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_CODE:  start_code_reg  <= cfg_data;
                REG_TOKEN_CODE:  token_code_reg  <= cfg_data;
                REG_END_CODE:    end_code_reg    <= cfg_data;
                REG_FRAME_LIMIT: frame_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
        end else if (push) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 8'd0;
            left_reg   <= 8'd0;
            addr_reg   <= 8'd0;
            index_reg  <= 8'd0;
            length_reg <= 8'd0;
            chk_lo_reg <= 8'd0;
            chk_hi_reg <= 8'd0;
        end else if (push) begin
            count_reg  <= count_next;
            left_reg   <= left_next;
            addr_reg   <= addr_next;
            index_reg  <= index_next;
            length_reg <= length_next;
            chk_lo_reg <= chk_lo_next;
            chk_hi_reg <= chk_hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (push) begin
                out_reg <= item_next;
            end
        end else if (push) begin
            skid_reg <= item_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.done;
    assign m_tdata  = {6'd0, out_reg.data};

endmodule

// File: design/smd_checker.sv
// Port-level checker for the serial message deframer, bound to the top level.
`include "serial_message_deframer_core_macros.svh"

module smd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    `SMD_ASSERT_NOW(a_done_not_dropped, m_tvalid, !(m_tlast && m_tdata[17]))
    `SMD_ASSERT_NOW(a_payload_is_stored, m_tvalid && m_tdata[16], m_tdata[8])
    `SMD_ASSERT_NOW(a_unstored_no_position, m_tvalid && !m_tdata[8], m_tdata[15:9] == 7'd0)
    `SMD_ASSERT_NOW(a_header_only_on_done, m_tvalid && !m_tlast, m_tdata[57:18] == 40'd0)
    `SMD_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind serial_message_deframer_core smd_checker u_smd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: test/tb_serial_message_deframer_core.sv
// Self-checking testbench for the serial message deframer core with random stalls on the input and result ports.
`timescale 1ns / 1ps

module tb_serial_message_deframer_core;
    import smd_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int PHASE_ITEMS     = 150;
    localparam int RESULT_BITS     = $bits(result_t);

    localparam logic [7:0] DIRECTED_BYTES [24] = '{
        8'h00, 8'hFF,
        RST_START_CODE, 8'hFF, 8'h00, 8'h00, RST_TOKEN_CODE, 8'h34, 8'h12, RST_END_CODE,
        RST_START_CODE, 8'h01, 8'h02, 8'h01, RST_TOKEN_CODE, 8'hAA, 8'h55, 8'h66, 8'h00,
        RST_START_CODE, 8'h80, 8'h7F, 8'h05, 8'h15
    };

    class deframe_scoreboard;
        item_t      expected_results[$];
        logic [7:0] open_byte;
        logic [7:0] token_byte;
        logic [7:0] close_byte;
        logic [7:0] capacity;
        state_t     rx_state;
        logic [7:0] fill_count;
        logic [7:0] payload_remaining;
        logic [7:0] addr_seen;
        logic [7:0] index_seen;
        logic [7:0] length_seen;
        logic [7:0] check_lo;
        logic [7:0] check_hi;
        int         mismatches;

        function new();
            open_byte         = RST_START_CODE;
            token_byte        = RST_TOKEN_CODE;
            close_byte        = RST_END_CODE;
            capacity          = RST_FRAME_LIMIT;
            rx_state          = ST_HUNT;
            fill_count        = '0;
            payload_remaining = '0;
            addr_seen         = '0;
            index_seen        = '0;
            length_seen       = '0;
            check_lo          = '0;
            check_hi          = '0;
            mismatches        = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                REG_START_CODE:  open_byte = value;
                REG_TOKEN_CODE:  token_byte = value;
                REG_END_CODE:    close_byte = value;
                REG_FRAME_LIMIT: capacity = value;
                default: ;
            endcase
        endfunction

        function void predict_byte(logic [7:0] b);
            item_t e;
            int    cap;
            e = '0;
            e.data.byte_value = b;
            cap = (int'(capacity) > FRAME_BYTES) ? FRAME_BYTES : int'(capacity);
            case (rx_state)
                ST_ADDR, ST_INDEX, ST_LENGTH, ST_CHECK_L, ST_CHECK_H: begin
                    e.data.byte_stored   = 1'b1;
                    e.data.byte_position = fill_count[6:0];
                    fill_count = fill_count + 8'd1;
                    case (rx_state)
                        ST_ADDR: begin
                            addr_seen = b;
                            rx_state  = ST_INDEX;
                        end
                        ST_INDEX: begin
                            index_seen = b;
                            rx_state   = ST_LENGTH;
                        end
                        ST_LENGTH: begin
                            length_seen       = b;
                            payload_remaining = b;
                            rx_state          = ST_TOKEN;
                        end
                        ST_CHECK_L: begin
                            check_lo = b;
                            rx_state = ST_CHECK_H;
                        end
                        default: begin
                            check_hi = b;
                            rx_state = ST_END;
                        end
                    endcase
                end
                ST_TOKEN: begin
                    if (b == token_byte) begin
                        e.data.byte_stored   = 1'b1;
                        e.data.byte_position = fill_count[6:0];
                        fill_count = fill_count + 8'd1;
                        rx_state = (payload_remaining != 8'd0) ? ST_DATA : ST_CHECK_L;
                    end else begin
                        e.data.frame_dropped = 1'b1;
                        rx_state = ST_HUNT;
                    end
                end
                ST_DATA: begin
                    e.data.byte_stored   = 1'b1;
                    e.data.is_payload    = 1'b1;
                    e.data.byte_position = fill_count[6:0];
                    fill_count        = fill_count + 8'd1;
                    payload_remaining = payload_remaining - 8'd1;
                    if (payload_remaining == 8'd0) begin
                        rx_state = ST_CHECK_L;
                    end
                    // The capacity test also applies to the last payload item.
                    if (int'(fill_count) + HDR_BYTES > cap) begin
                        e.data.frame_dropped = 1'b1;
                        rx_state = ST_HUNT;
                    end
                end
                ST_END: begin
                    e.data.byte_stored   = 1'b1;
                    e.data.byte_position = fill_count[6:0];
                    fill_count = fill_count + 8'd1;
                    rx_state = ST_HUNT;
                    if (b == close_byte) begin
                        e.done = 1'b1;
                    end else begin
                        e.data.frame_dropped = 1'b1;
                    end
                end
                default: begin
                    rx_state   = ST_HUNT;
                    fill_count = 8'd1;
                    if (b == open_byte) begin
                        e.data.byte_stored = 1'b1;
                        rx_state = ST_ADDR;
                    end
                end
            endcase
            if (e.done) begin
                e.data.frame_addr   = addr_seen;
                e.data.frame_index  = index_seen;
                e.data.frame_length = length_seen;
                e.data.frame_check  = {check_hi, check_lo};
            end
            expected_results.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
            if (exp !== got) begin
                $error("%s: expected %0h, got %0h", name, exp, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [63:0] tdata, logic tlast);
            item_t   e;
            result_t got;
            if (expected_results.size() == 0) begin
                $error("result item with no byte pending: tdata %0h", tdata);
                mismatches++;
                return;
            end
            e   = expected_results.pop_front();
            got = result_t'(tdata[RESULT_BITS-1:0]);
            compare_field("byte_value", e.data.byte_value, got.byte_value);
            compare_field("byte_stored", e.data.byte_stored, got.byte_stored);
            compare_field("byte_position", e.data.byte_position, got.byte_position);
            compare_field("is_payload", e.data.is_payload, got.is_payload);
            compare_field("frame_dropped", e.data.frame_dropped, got.frame_dropped);
            compare_field("frame_addr", e.data.frame_addr, got.frame_addr);
            compare_field("frame_index", e.data.frame_index, got.frame_index);
            compare_field("frame_length", e.data.frame_length, got.frame_length);
            compare_field("frame_check", e.data.frame_check, got.frame_check);
            compare_field("tdata padding", '0, tdata[63:RESULT_BITS]);
            compare_field("frame_done", e.done, tlast);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    deframe_scoreboard sb;
    bit                send_idle;
    bit                recv_idle;
    int                bytes_sent;
    int                idle_cycles;

    serial_message_deframer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        @(negedge aclk);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        logic [7:0] frame_q[$];
        int         kind;
        int         len;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
        end else begin
            len = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 130) : $urandom_range(0, 12);
            frame_q.push_back(sb.open_byte);
            frame_q.push_back(8'($urandom));
            frame_q.push_back(8'($urandom));
            frame_q.push_back(8'(len));
            if (kind == 1) begin
                frame_q.push_back(sb.token_byte ^ 8'($urandom_range(1, 255)));
            end else begin
                frame_q.push_back(sb.token_byte);
                repeat (len) frame_q.push_back(8'($urandom));
                frame_q.push_back(8'($urandom));
                frame_q.push_back(8'($urandom));
                frame_q.push_back((kind == 2) ? sb.close_byte ^ 8'($urandom_range(1, 255))
                                              : sb.close_byte);
            end
        end
        foreach (frame_q[i]) send_byte(frame_q[i]);
    endtask

    task automatic run_traffic(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            send_idle = ($urandom_range(0, 3) != 0);
            send_frame();
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] start_code, input logic [7:0] token_code,
                             input logic [7:0] close_code, input logic [7:0] limit);
        drain();
        write_reg(REG_START_CODE, start_code);
        write_reg(REG_TOKEN_CODE, token_code);
        write_reg(REG_END_CODE, close_code);
        write_reg(REG_FRAME_LIMIT, limit);
    endtask

    initial begin
        int gap;
        int left;
        left = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (left == 0) begin
                recv_idle = ($urandom_range(0, 3) != 0);
                left = $urandom_range(8, 40);
            end
            left--;
            gap = recv_idle ? $urandom_range(0, 7) : 0;
            @(negedge aclk);
            repeat (gap) begin
                m_tready <= 1'b0;
                @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tlast);
        end
    end

    initial begin
        sb = new();
        bytes_sent  = 0;
        idle_cycles = 0;
        send_idle   = 1'b1;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_START_CODE;
        cfg_data  <= '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);

        configure(8'h00, 8'hFF, 8'h00, 8'd16);
        run_traffic(PHASE_ITEMS);
        configure(8'hFF, 8'h00, 8'hFF, 8'd128);
        run_traffic(PHASE_ITEMS);
        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
        run_traffic(PHASE_ITEMS);
        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(16, 128)));
        run_traffic(PHASE_ITEMS);
        configure(RST_START_CODE, RST_TOKEN_CODE, RST_END_CODE, RST_FRAME_LIMIT);
        run_traffic(PHASE_ITEMS);

        drain();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/smd_pkg.sv
design/serial_message_deframer_core.sv
design/smd_checker.sv
test/tb_serial_message_deframer_core.sv
